[sv/rpfa_pkg.sv]
// Shared widths, codes, controller states and command/status structs for the frame allocator.
`default_nettype none

package rpfa_pkg;

	localparam int FRAME_W    = 13;
	localparam int CNT_W      = 8;
	localparam int FREE_W     = 14;
	localparam int START_W    = 13;
	localparam int TOTAL_W    = 14;
	localparam int KIND_W     = 2;
	localparam int STATUS_W   = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 14;

	// scan index covers every frame below the largest total_frames value
	localparam int SCAN_W     = TOTAL_W;
	localparam int SCAN_SPAN  = 1 << SCAN_W;
	localparam int LIM_W      = SCAN_W + 1;

	localparam int NUM_FRAMES_DEF = 8192;

	localparam logic [TOTAL_W-1:0] TOTAL_RST  = TOTAL_W'(8192);
	localparam logic [FREE_W-1:0]  FREE_MAX   = '1;
	// an add-reference whose new count would reach 255 is refused
	localparam logic [CNT_W-1:0]   CNT_OVF_AT = CNT_W'(254);

	localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ADDREF  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_BAD     = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_OOM      = 3'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_UNALLOC  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_START = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TOTAL = 2'd1;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_LOOKUP,
		S_FINISH
	} ctl_state_t;

	typedef struct packed {
		logic clr_we;
		logic load_item;
		logic scan_step;
		logic lookup_rd;
		logic commit;
	} dp_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic scan_done;
	} dp_sts_t;

endpackage

`default_nettype wire

[sv/refcounted_page_frame_allocator.sv]
// Top level of the reference-counted page frame allocator: controller plus datapath.
`default_nettype none

// Reference-counted page frame allocator. Holds an 8-bit reference count for
// each of NUM_FRAMES frames in a single-port-write, registered-read memory and
// a 14-bit free-frame counter. kind 0 allocates the lowest frame at or above
// start_frame whose count is zero, kind 1 drops one reference, kind 2 adds one;
// each transaction on the input channel yields exactly one result transaction.
// After reset the block sweeps the count store to zero, one frame per cycle, so
// in_ready stays low while the sweep runs; configuration writes are taken at
// any time, cfg_ready is always high, and each write to start_frame or
// total_frames reloads the free count. Only write configuration while idle.
// One item is in work at a time. Release and add-reference pass through accept,
// count read and update. An allocation reads one count per cycle from the
// memory's single read port, starting at start_frame, until it finds a zero
// count or reaches the limit. A finished result waits in the output register
// without blocking the next accept.
module refcounted_page_frame_allocator #(
	parameter int NUM_FRAMES = rpfa_pkg::NUM_FRAMES_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// item channel
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [rpfa_pkg::KIND_W-1:0]     kind,
	input  wire logic [rpfa_pkg::FRAME_W-1:0]    frame,
	// result channel
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [rpfa_pkg::FRAME_W-1:0]         frame_out,
	output logic [rpfa_pkg::STATUS_W-1:0]        status,
	output logic [rpfa_pkg::CNT_W-1:0]           ref_count,
	output logic [rpfa_pkg::FREE_W-1:0]          free_count,
	// configuration write channel
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [rpfa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [rpfa_pkg::CFG_DATA_W-1:0] cfg_data
);
	import rpfa_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	// register writes never stall
	assign cfg_ready = 1'b1;

	// sequence clearing, scan and commit
	rpfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// hold counts, configuration and the result register
	rpfa_dp #(
		.NUM_FRAMES (NUM_FRAMES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.kind       (kind),
		.frame      (frame),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.frame_out  (frame_out),
		.status     (status),
		.ref_count  (ref_count),
		.free_count (free_count)
	);

endmodule

`default_nettype wire

[sv/rpfa_ctrl.sv]
// Controller state machine: clearing pass, item dispatch, scan sequencing and result handoff.
`default_nettype none

module rpfa_ctrl (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [rpfa_pkg::KIND_W-1:0] kind,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	input  wire rpfa_pkg::dp_sts_t          sts,
	output rpfa_pkg::dp_cmd_t               cmd
);
	import rpfa_pkg::*;

	ctl_state_t state_q, state_d;
	logic       out_valid_q;
	logic       slot_free;

	// result register is free, or empties in this cycle
	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR:  if (sts.clr_last) state_d = S_IDLE;
			S_IDLE:   if (in_valid) state_d = (kind == KIND_ALLOC) ? S_SCAN : S_LOOKUP;
			S_SCAN:   if (sts.scan_done) state_d = S_FINISH;
			S_LOOKUP: state_d = S_FINISH;
			S_FINISH: if (slot_free) state_d = S_IDLE;
			default:  state_d = S_CLEAR;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_CLEAR:  cmd.clr_we = 1'b1;
			S_IDLE: begin
				in_ready      = 1'b1;
				cmd.load_item = in_valid;
			end
			S_SCAN:   cmd.scan_step = !sts.scan_done;
			S_LOOKUP: cmd.lookup_rd = 1'b1;
			S_FINISH: cmd.commit = slot_free;
			default:  cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q)
		else $error("committed result not presented");
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second item taken while one is in work");
	a_clear_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR && sts.clr_last) |=> state_q == S_IDLE)
		else $error("clearing pass did not hand over to idle");
`endif

endmodule

`default_nettype wire

[sv/rpfa_dp.sv]
// Datapath: count store, clearing sweep, scan pointer, configuration and result registers.
`default_nettype none

module rpfa_dp #(
	parameter int NUM_FRAMES = rpfa_pkg::NUM_FRAMES_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire rpfa_pkg::dp_cmd_t              cmd,
	output rpfa_pkg::dp_sts_t                   sts,
	input  wire logic [rpfa_pkg::KIND_W-1:0]     kind,
	input  wire logic [rpfa_pkg::FRAME_W-1:0]    frame,
	input  wire logic                           cfg_we,
	input  wire logic [rpfa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [rpfa_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic [rpfa_pkg::FRAME_W-1:0]         frame_out,
	output logic [rpfa_pkg::STATUS_W-1:0]        status,
	output logic [rpfa_pkg::CNT_W-1:0]           ref_count,
	output logic [rpfa_pkg::FREE_W-1:0]          free_count
);
	import rpfa_pkg::*;

	localparam int AW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
	localparam logic [LIM_W-1:0] NF_CLIP =
		(NUM_FRAMES >= SCAN_SPAN) ? LIM_W'(SCAN_SPAN) : LIM_W'(NUM_FRAMES);
	localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_FRAMES - 1);

	logic [CNT_W-1:0]   mem [NUM_FRAMES];
	logic [CNT_W-1:0]   rd_data_q;
	logic [AW-1:0]      clr_addr_q;

	logic [START_W-1:0] start_q, start_d;
	logic [TOTAL_W-1:0] total_q, total_d;
	logic [FREE_W-1:0]  free_q, free_d, free_reload;
	logic               cfg_hit;
	logic [LIM_W-1:0]   lim, lim_new;

	logic [KIND_W-1:0]  kind_q;
	logic [FRAME_W-1:0] frame_q;
	logic [SCAN_W-1:0]  scan_q;
	logic [SCAN_W-1:0]  addr_s1;
	logic               pend_s1;
	logic               scan_issue;
	logic               scan_hit;
	logic               in_range;

	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic [CNT_W-1:0]   wr_data;
	logic               mem_we;
	logic [AW-1:0]      mem_wa;
	logic [CNT_W-1:0]   mem_wd;

	logic [FRAME_W-1:0]  res_frame;
	logic [STATUS_W-1:0] res_status;
	logic [CNT_W-1:0]    res_cnt;

	logic [FRAME_W-1:0]  frame_out_q;
	logic [STATUS_W-1:0] status_q;
	logic [CNT_W-1:0]    ref_count_q;
	logic [FREE_W-1:0]   free_count_q;

	function automatic logic [LIM_W-1:0] clip_lim(input logic [TOTAL_W-1:0] t);
		logic [LIM_W-1:0] tw;
		tw = LIM_W'(t);
		clip_lim = (tw < NF_CLIP) ? tw : NF_CLIP;
	endfunction

	// configuration and free-count reload
	assign cfg_hit     = (cfg_index == CFG_START) || (cfg_index == CFG_TOTAL);
	assign start_d     = (cfg_index == CFG_START) ? cfg_data[START_W-1:0] : start_q;
	assign total_d     = (cfg_index == CFG_TOTAL) ? cfg_data[TOTAL_W-1:0] : total_q;
	assign lim_new     = clip_lim(total_d);
	assign free_reload = (lim_new > LIM_W'(start_d)) ?
		FREE_W'(lim_new - LIM_W'(start_d)) : '0;
	assign lim         = clip_lim(total_q);

	assign in_range = (frame_q >= start_q) && (LIM_W'(frame_q) < lim);

	// scan: one read issued per step, data checked in the next cycle
	assign scan_issue    = cmd.scan_step && (LIM_W'(scan_q) < lim);
	assign scan_hit      = pend_s1 && (rd_data_q == '0);
	assign sts.scan_done = scan_hit || (!pend_s1 && !(LIM_W'(scan_q) < lim));
	assign sts.clr_last  = (clr_addr_q == LAST_ADDR);

	assign rd_en   = scan_issue || cmd.lookup_rd;
	assign rd_addr = cmd.lookup_rd ? AW'(frame_q) : AW'(scan_q);

	always_comb begin
		res_frame  = frame_q;
		res_status = ST_OK;
		res_cnt    = '0;
		wr_en      = 1'b0;
		wr_addr    = AW'(frame_q);
		wr_data    = '0;
		free_d     = free_q;
		priority if (kind_q == KIND_ALLOC) begin
			res_frame  = '0;
			res_status = ST_OOM;
			wr_addr    = AW'(addr_s1);
			if (scan_hit) begin
				res_frame  = addr_s1[FRAME_W-1:0];
				res_status = ST_OK;
				res_cnt    = CNT_W'(1);
				wr_en      = 1'b1;
				wr_data    = CNT_W'(1);
				if (free_q != '0)
					free_d = free_q - FREE_W'(1);
			end
		end else if (kind_q == KIND_BAD || !in_range) begin
			res_status = ST_RANGE;
		end else if (rd_data_q == '0) begin
			res_status = ST_UNALLOC;
		end else if (kind_q == KIND_RELEASE) begin
			res_cnt = rd_data_q - CNT_W'(1);
			wr_en   = 1'b1;
			wr_data = rd_data_q - CNT_W'(1);
			if (rd_data_q == CNT_W'(1) && free_q != FREE_MAX)
				free_d = free_q + FREE_W'(1);
		end else if (rd_data_q >= CNT_OVF_AT) begin
			res_status = ST_OVERFLOW;
			res_cnt    = rd_data_q;
		end else begin
			res_cnt = rd_data_q + CNT_W'(1);
			wr_en   = 1'b1;
			wr_data = rd_data_q + CNT_W'(1);
		end
	end

	// single write port: sweep during clearing, result write at commit
	assign mem_we = cmd.clr_we || (cmd.commit && wr_en);
	assign mem_wa = cmd.clr_we ? clr_addr_q : wr_addr;
	assign mem_wd = cmd.clr_we ? '0 : wr_data;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		if (rd_en)
			rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			start_q    <= '0;
			total_q    <= TOTAL_RST;
			free_q     <= '0;
			scan_q     <= '0;
			pend_s1    <= 1'b0;
		end else begin
			if (cmd.clr_we)
				clr_addr_q <= clr_addr_q + AW'(1);
			if (cfg_we && cfg_hit) begin
				start_q <= start_d;
				total_q <= total_d;
				free_q  <= free_reload;
			end else if (cmd.commit) begin
				free_q <= free_d;
			end
			if (cmd.load_item) begin
				scan_q  <= SCAN_W'(start_q);
				pend_s1 <= 1'b0;
			end else if (cmd.scan_step) begin
				pend_s1 <= scan_issue;
				if (scan_issue)
					scan_q <= scan_q + SCAN_W'(1);
			end else if (cmd.commit) begin
				pend_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			kind_q  <= kind;
			frame_q <= frame;
		end
		if (cmd.scan_step)
			addr_s1 <= scan_q;
		if (cmd.commit) begin
			frame_out_q  <= res_frame;
			status_q     <= res_status;
			ref_count_q  <= res_cnt;
			free_count_q <= free_d;
		end
	end

	assign frame_out  = frame_out_q;
	assign status     = status_q;
	assign ref_count  = ref_count_q;
	assign free_count = free_count_q;

`ifndef SYNTHESIS
	a_wr_in_store: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> ({1'b0, mem_wa} < (AW+1)'(NUM_FRAMES)))
		else $error("count store write beyond its depth");
	a_pend_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> (LIM_W'(addr_s1) < lim))
		else $error("scan data outstanding for a frame outside the limit");
	a_free_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && kind_q != KIND_ALLOC && !cfg_we) |=> free_q >= $past(free_q))
		else $error("free count fell on a release or add-reference");
`endif

endmodule

`default_nettype wire
